>>> src/bhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  // Storage geometry.
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;

  // Operation codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // Microcode fields.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_PARENT, RD_LEFT, RD_RIGHT, RD_ROOT, RD_LAST
  } rd_sel_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_POP, CAP_V, CAP_CAND, CAP_INIT, CAP_BEST_L, CAP_BEST_R
  } cap_t;

  typedef enum logic [1:0] {
    WR_NONE, WR_V, WR_CAND
  } wr_t;

  typedef enum logic [2:0] {
    POS_HOLD, POS_COUNT, POS_ZERO, POS_PARENT, POS_CAND
  } pos_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC
  } cnt_op_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_DISPATCH, C_CNT_ZERO, C_NOT_ABOVE, C_PARENT_ZERO,
    C_NO_LEFT, C_SELF, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    rd_sel_t rd;
    cap_t    cap;
    wr_t     wr;
    pos_op_t pos;
    cnt_op_t cnt;
    cond_t   cond;
    step_t   tgt;
    step_t   alt;
  } uword_t;

  // Program addresses.
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_PUSH     = 4'd1;
  localparam step_t S_PUP_RD   = 4'd2;
  localparam step_t S_PUP_CMP  = 4'd3;
  localparam step_t S_PUP_MOVE = 4'd4;
  localparam step_t S_PWRV     = 4'd5;
  localparam step_t S_POP      = 4'd6;
  localparam step_t S_POP_CAP  = 4'd7;
  localparam step_t S_POP_LAST = 4'd8;
  localparam step_t S_SD_RD_L  = 4'd9;
  localparam step_t S_SD_RD_R  = 4'd10;
  localparam step_t S_SD_CMP_R = 4'd11;
  localparam step_t S_SD_MOVE  = 4'd12;
  localparam step_t S_FINISH   = 4'd13;

  // Control store. Except C_DISPATCH: true to tgt, else to alt.
  function automatic uword_t ucode_rom(input step_t addr);
    uword_t uw;
    uw = '{RD_NONE, CAP_NONE, WR_NONE, POS_HOLD, CNT_HOLD, C_ALWAYS, S_IDLE, S_IDLE};
    unique case (addr)
      S_IDLE:
        uw = '{RD_NONE, CAP_NONE, WR_NONE, POS_HOLD, CNT_HOLD, C_DISPATCH,
               S_IDLE, S_IDLE};
      S_PUSH:
        uw = '{RD_NONE, CAP_NONE, WR_NONE, POS_COUNT, CNT_INC, C_CNT_ZERO,
               S_PWRV, S_PUP_RD};
      S_PUP_RD:
        uw = '{RD_PARENT, CAP_NONE, WR_NONE, POS_HOLD, CNT_HOLD, C_ALWAYS,
               S_PUP_CMP, S_PUP_CMP};
      S_PUP_CMP:
        uw = '{RD_NONE, CAP_CAND, WR_NONE, POS_HOLD, CNT_HOLD, C_NOT_ABOVE,
               S_PWRV, S_PUP_MOVE};
      S_PUP_MOVE:
        uw = '{RD_NONE, CAP_NONE, WR_CAND, POS_PARENT, CNT_HOLD, C_PARENT_ZERO,
               S_PWRV, S_PUP_RD};
      S_PWRV:
        uw = '{RD_NONE, CAP_NONE, WR_V, POS_HOLD, CNT_HOLD, C_ALWAYS,
               S_FINISH, S_FINISH};
      S_POP:
        uw = '{RD_ROOT, CAP_NONE, WR_NONE, POS_HOLD, CNT_DEC, C_ALWAYS,
               S_POP_CAP, S_POP_CAP};
      S_POP_CAP:
        uw = '{RD_LAST, CAP_POP, WR_NONE, POS_HOLD, CNT_HOLD, C_CNT_ZERO,
               S_FINISH, S_POP_LAST};
      S_POP_LAST:
        uw = '{RD_NONE, CAP_V, WR_NONE, POS_ZERO, CNT_HOLD, C_ALWAYS,
               S_SD_RD_L, S_SD_RD_L};
      S_SD_RD_L:
        uw = '{RD_LEFT, CAP_INIT, WR_NONE, POS_HOLD, CNT_HOLD, C_NO_LEFT,
               S_PWRV, S_SD_RD_R};
      S_SD_RD_R:
        uw = '{RD_RIGHT, CAP_BEST_L, WR_NONE, POS_HOLD, CNT_HOLD, C_ALWAYS,
               S_SD_CMP_R, S_SD_CMP_R};
      S_SD_CMP_R:
        uw = '{RD_NONE, CAP_BEST_R, WR_NONE, POS_HOLD, CNT_HOLD, C_ALWAYS,
               S_SD_MOVE, S_SD_MOVE};
      S_SD_MOVE:
        uw = '{RD_NONE, CAP_NONE, WR_CAND, POS_CAND, CNT_HOLD, C_SELF,
               S_FINISH, S_SD_RD_L};
      S_FINISH:
        uw = '{RD_NONE, CAP_NONE, WR_NONE, POS_HOLD, CNT_HOLD, C_OUT_FREE,
               S_IDLE, S_FINISH};
      default:
        uw = '{RD_NONE, CAP_NONE, WR_NONE, POS_HOLD, CNT_HOLD, C_ALWAYS,
               S_IDLE, S_IDLE};
    endcase
    return uw;
  endfunction

  // True when a belongs above b in the selected order.
  function automatic logic ranks_above(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b,
                                       input logic min_order);
    return min_order ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

>>> src/bhpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/binary_heap_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// A sift level costs three program steps up and four down; in each, the read steps and the
// move step use the heap store. Empty pops and full pushes go from idle straight to the
// finish step. One request is in work at a time; the next is taken in the cycle after the
// result is loaded, while it may still wait in the output register.
// Reset (rst, synchronous) clears the entry count, min_mode, the output valid flag and the
// sequencer; the heap store keeps whatever it held and needs no clearing pass.

module binary_heap_priority_queue_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bhpq_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bhpq_pkg::out_item_t       out_data
);

  import bhpq_pkg::*;

  logic                     min_mode;
  step_t                    step;
  step_t                    step_next;
  uword_t                   uw;
  logic [ADDR_W-1:0]        pos;
  logic [CNT_W-1:0]         cnt;
  logic signed [DATA_W-1:0] v;
  logic signed [DATA_W-1:0] cand;
  logic [ADDR_W-1:0]        cand_idx;
  logic                     self_pick;
  logic signed [DATA_W-1:0] popped;
  logic [1:0]               status;

  logic                     in_fire;
  logic                     out_free;
  logic [IDX_W-1:0]         left_idx;
  logic [IDX_W-1:0]         right_idx;
  logic                     left_ok;
  logic                     right_ok;
  logic [ADDR_W-1:0]        parent_idx;
  logic                     is_full;
  logic                     is_empty;
  logic                     cond_true;
  step_t                    dispatch;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_val;
  logic                     v_above_rd;
  logic                     rd_above_cand;

  // Heap storage.
  bhpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Current control word.
  assign uw       = ucode_rom(step);
  assign in_ready = (step == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Tree index arithmetic.
  assign left_idx   = {1'b0, pos, 1'b1};
  assign right_idx  = {1'b0, pos, 1'b0} + IDX_W'(2);
  assign left_ok    = left_idx < IDX_W'(cnt);
  assign right_ok   = right_idx < IDX_W'(cnt);
  assign parent_idx = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign is_full    = (cnt == CNT_W'(CAPACITY));
  assign is_empty   = (cnt == '0);

  // Comparators on the read data.
  assign rd_val        = $signed(ram_rdata);
  assign v_above_rd    = ranks_above(v, rd_val, min_mode);
  assign rd_above_cand = ranks_above(rd_val, cand, min_mode);

  // Read address selection.
  always_comb begin
    unique case (uw.rd)
      RD_PARENT: ram_raddr = parent_idx;
      RD_LEFT:   ram_raddr = left_idx[ADDR_W-1:0];
      RD_RIGHT:  ram_raddr = right_idx[ADDR_W-1:0];
      RD_LAST:   ram_raddr = ADDR_W'(cnt);
      default:   ram_raddr = '0;
    endcase
  end

  // Write port: either the moving value or the candidate goes to the hole.
  assign ram_we    = (uw.wr != WR_NONE);
  assign ram_waddr = pos;
  assign ram_wdata = (uw.wr == WR_CAND) ? cand : v;

  // Entry dispatch from idle.
  always_comb begin
    if (in_data.cmd == CMD_PUSH) begin
      dispatch = is_full ? S_FINISH : S_PUSH;
    end else begin
      dispatch = is_empty ? S_FINISH : S_POP;
    end
  end

  // Jump condition.
  always_comb begin
    unique case (uw.cond)
      C_DISPATCH:    cond_true = in_fire;
      C_CNT_ZERO:    cond_true = is_empty;
      C_NOT_ABOVE:   cond_true = !v_above_rd;
      C_PARENT_ZERO: cond_true = (parent_idx == '0);
      C_NO_LEFT:     cond_true = !left_ok;
      C_SELF:        cond_true = self_pick;
      C_OUT_FREE:    cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (uw.cond == C_DISPATCH) begin
      step_next = in_fire ? dispatch : S_IDLE;
    end else begin
      step_next = cond_true ? uw.tgt : uw.alt;
    end
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      cnt       <= '0;
      min_mode  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        min_mode <= cfg_wdata;
      end
      unique case (uw.cnt)
        CNT_INC: cnt <= cnt + CNT_W'(1);
        CNT_DEC: cnt <= cnt - CNT_W'(1);
        default: cnt <= cnt;
      endcase
      if (step == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      v      <= in_data.value;
      popped <= '0;
      if (in_data.cmd == CMD_PUSH) begin
        status <= is_full ? ST_FULL : ST_OK;
      end else begin
        status <= is_empty ? ST_EMPTY : ST_OK;
      end
    end

    unique case (uw.pos)
      POS_COUNT:  pos <= ADDR_W'(cnt);
      POS_ZERO:   pos <= '0;
      POS_PARENT: pos <= parent_idx;
      POS_CAND:   pos <= cand_idx;
      default:    pos <= pos;
    endcase

    case (uw.cap)
      CAP_POP:  popped <= rd_val;
      CAP_V:    v      <= rd_val;
      CAP_CAND: cand   <= rd_val;
      CAP_INIT: begin
        cand      <= v;
        cand_idx  <= pos;
        self_pick <= 1'b1;
      end
      CAP_BEST_L: begin
        if (rd_above_cand) begin
          cand      <= rd_val;
          cand_idx  <= left_idx[ADDR_W-1:0];
          self_pick <= 1'b0;
        end
      end
      CAP_BEST_R: begin
        if (right_ok && rd_above_cand) begin
          cand      <= rd_val;
          cand_idx  <= right_idx[ADDR_W-1:0];
          self_pick <= 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (step == S_FINISH && out_free) begin
      out_data.popped    <= popped;
      out_data.status    <= status;
      out_data.occupancy <= OCC_W'(cnt);
    end
  end

`ifndef NO_ASSERTIONS
  // The entry count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every store write lands inside the occupied region.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (IDX_W'(ram_waddr) < IDX_W'(cnt)))
    else $error("heap write outside occupied entries");

  // A dropped push is reported only with a full heap.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_FULL) |->
      (out_data.occupancy == OCC_W'(CAPACITY) && out_data.popped == '0))
    else $error("full status with wrong occupancy");

  // An empty pop reports an empty heap and a zero value.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.occupancy == '0 && out_data.popped == '0))
    else $error("empty status with nonzero fields");
`endif

endmodule

`default_nettype wire

>>> dv/binary_heap_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module binary_heap_priority_queue_core_tb;
  import bhpq_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEGMENTS      = 16;
  localparam int SEG_ITEMS     = 50;

  // Keeps its own copy of the heap and predicts every result in order.
  class heap_scoreboard;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int                       held;
    logic                     min_order;
    out_item_t                waiting [$];
    int errors, pushes, pops, empty_pops, full_drops, order_writes;

    function new();
      held = 0;
      min_order = 1'b0;
      errors = 0;
      pushes = 0;
      pops = 0;
      empty_pops = 0;
      full_drops = 0;
      order_writes = 0;
    endfunction

    function void set_order(input logic min_sel);
      min_order = min_sel;
      order_writes++;
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    // A moves above b only when strictly better in the current order.
    function bit outranks(input logic signed [DATA_W-1:0] a,
                          input logic signed [DATA_W-1:0] b);
      return min_order ? (a < b) : (a > b);
    endfunction

    function void exchange(input int i, input int j);
      logic signed [DATA_W-1:0] t;
      t = slots[i];
      slots[i] = slots[j];
      slots[j] = t;
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(input in_item_t req);
      out_item_t exp;
      int pos, parent, lchild, rchild, best;
      exp = '0;
      exp.status = ST_OK;
      if (req.cmd == CMD_PUSH) begin
        if (held >= CAPACITY) begin
          exp.status = ST_FULL;
          full_drops++;
        end else begin
          slots[held] = req.value;
          pos = held;
          held++;
          pushes++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!outranks(slots[pos], slots[parent])) break;
            exchange(pos, parent);
            pos = parent;
          end
        end
      end else if (held == 0) begin
        exp.status = ST_EMPTY;
        empty_pops++;
      end else begin
        exp.popped = slots[0];
        held--;
        slots[0] = slots[held];
        pops++;
        pos = 0;
        forever begin
          lchild = 2 * pos + 1;
          rchild = lchild + 1;
          best = pos;
          if (lchild < held && outranks(slots[lchild], slots[best])) best = lchild;
          if (rchild < held && outranks(slots[rchild], slots[best])) best = rchild;
          if (best == pos) break;
          exchange(pos, best);
          pos = best;
        end
      end
      exp.occupancy = OCC_W'(held);
      waiting.push_back(exp);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(input out_item_t got);
      out_item_t exp;
      if (waiting.size() == 0) begin
        $error("unexpected result: popped=%0d status=%0d occupancy=%0d",
               got.popped, got.status, got.occupancy);
        errors++;
        return;
      end
      exp = waiting.pop_front();
      if (got.popped !== exp.popped) begin
        $error("popped: expected %0d, got %0d", exp.popped, got.popped);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  logic      idle_en = 1'b1;
  logic      hold_req = 1'b0;
  int        cycles = 0;

  heap_scoreboard sb;

  binary_heap_priority_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both handshakes at the edge; results are checked before new requests are noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_request(in_data);
    end
  end

  // Result side: random stall bursts, free-running stretches, one long hold-off, and always ready once idles are off.
  initial begin : result_sink
    int   stall_left;
    int   run_left;
    int   hold_left;
    logic rdy;
    stall_left = 0;
    run_left = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!idle_en) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        rdy = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 9);
        rdy = 1'b0;
      end else begin
        run_left = $urandom_range(0, 30);
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // Half full-range values, a quarter extremes, and a quarter from a narrow band that forces ties.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed(DATA_W'($urandom_range(0, 8))) - 4;
      default: return $signed(DATA_W'($urandom));
    endcase
  endfunction

  // Offer one request and return at the edge where it is taken; valid stays up.
  task automatic send_request(input logic cmd, input logic signed [DATA_W-1:0] v);
    in_item_t req;
    req.cmd = cmd;
    req.value = v;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  // The falling edge lets the sampler note the last accepted request first.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the heap order while nothing is in flight.
  task automatic write_order(input logic min_sel);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= min_sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_order(min_sel);
  endtask

  initial begin : stimulus
    int push_pct;
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, value extremes and ties in max order.
    send_request(CMD_POP, $signed(DATA_W'($urandom)));
    send_request(CMD_PUSH, 32'sh7fff_ffff);
    send_request(CMD_PUSH, 32'sh8000_0000);
    send_request(CMD_PUSH, -32'sd1);
    send_request(CMD_PUSH, -32'sd1);
    send_request(CMD_POP, 32'sh7fff_ffff);

    // Switch to min order with entries still held; they are not reordered.
    write_order(1'b1);
    send_request(CMD_POP, 32'sh8000_0000);

    // Fill to capacity with repeated values, then one push too many.
    for (int k = 0; k < 14; k++) send_request(CMD_PUSH, $signed(DATA_W'(k % 7)) - 3);
    send_request(CMD_PUSH, 32'sd5);
    send_request(CMD_POP, '0);

    // Random segments alternate between filling, draining and a balanced mix.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_en = (seg < SEGMENTS - 3);
      write_order(seg == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
      push_pct = (seg % 3 == 0) ? 75 : (seg % 3 == 1) ? 25 : 50;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 4 && n == 20) hold_req = 1'b1;
        if ($urandom_range(1, 100) <= push_pct)
          send_request(CMD_PUSH, pick_value());
        else
          send_request(CMD_POP, $signed(DATA_W'($urandom)));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d pushes, %0d pops, %0d pops when empty and %0d dropped pushes,",
             sb.pushes, sb.pops, sb.empty_pops, sb.full_drops);
    $display("across %0d order settings, with %0d field mismatches.",
             sb.order_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
